@@ rtl/core/pwvg_pkg.sv @@
// ----------------------------------------------------------------------------
// pwvg_pkg
// Shared types, wave codes and the quarter-wave sine generator function for
// the periodic waveform value generator.
// ----------------------------------------------------------------------------
package pwvg_pkg;

	typedef enum logic [2:0] {
		WAVE_SAW     = 3'd0,
		WAVE_INV_SAW = 3'd1,
		WAVE_SINE    = 3'd2,
		WAVE_SQUARE  = 3'd3,
		WAVE_TRI     = 3'd4
	} wave_e;

	typedef struct packed {
		logic [31:0]        time_ms;
		logic [23:0]        period_ms;
		logic [2:0]         wave_code;
		logic signed [31:0] high_limit;
		logic signed [31:0] low_limit;
	} pwvg_in_t;

	typedef struct packed {
		logic [16:0]        amplitude;
		logic               above_half;
		logic signed [31:0] scaled_value;
		logic               period_error;
	} pwvg_out_t;

	localparam logic [16:0] AMP_ONE  = 17'd65536;
	localparam logic [16:0] AMP_HALF = 17'd32768;

	// sin(pi/2 * k / 2^tb) in Q16 by a Taylor series in Q30, elaboration time only
	function automatic logic [16:0] quarter_sine(input int unsigned k, input int unsigned tb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		x    = (longint'(k) * 64'd1686629713) >> tb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		sum  = (sum + 64'd8192) >> 14;
		if (sum > 64'd65536) begin
			sum = 64'd65536;
		end
		return sum[16:0];
	endfunction

endpackage

@@ rtl/core/periodic_waveform_value_generator.sv @@
// ----------------------------------------------------------------------------
// periodic_waveform_value_generator
// Phase from time and period, wave shaping and scaling between two limits.
// ----------------------------------------------------------------------------
// Usage: each input beat (in_valid/in_ready, in_data) carries a millisecond
// time, a period, a wave code and two Q16.16 limits. Each input beat gives
// exactly one output beat (out_valid/out_ready, out_data) with the Q16
// amplitude, an above-half flag, the scaled value and a zero-period flag.
// Throughput: one beat per cycle while the output is not held. From
// acceptance to out_valid a beat passes the input register, then the
// restoring divider, which retires one quotient bit per stage over the 32
// time bits and the PHASE_BITS phase bits, then four stages for the sine
// ROM read, amplitude select, multiply and final add.
// The whole pipeline advances together: when the output beat is held by
// the receiver, in_ready drops and every stage holds its contents, so
// nothing is lost or repeated. Reset clears all valid bits; the block takes
// a beat in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module periodic_waveform_value_generator #(
	parameter int PHASE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pwvg_pkg::pwvg_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pwvg_pkg::pwvg_out_t out_data
);
	import pwvg_pkg::*;

	localparam int PB   = PHASE_BITS;
	localparam int STB  = SINE_TABLE_BITS;
	localparam int N    = 32 + PB;
	localparam int UP   = (PB < 16) ? 16 - PB : 0;
	localparam int DN   = (PB > 16) ? PB - 16 : 0;
	localparam int AW   = PB + 2 + UP;
	localparam int TB   = STB + 2;
	localparam int SUP  = (TB > PB) ? TB - PB : 0;
	localparam int SDN  = (PB > TB) ? PB - TB : 0;
	localparam int QW   = PB + SUP;
	localparam int QSZ  = 1 << STB;
	localparam logic [PB+1:0] ONE = (PB+2)'(1) << PB;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// divider stages
	logic        v_s   [0:N];
	logic [23:0] rem_s [0:N];
	logic [31:0] dvd_s [0:N];
	logic [PB-1:0] quo_s [0:N];
	logic [23:0] per_s [0:N];
	logic [2:0]  code_s [0:N];
	logic signed [31:0] hi_s [0:N];
	logic signed [31:0] lo_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			dvd_s[0]  <= in_data.time_ms;
			quo_s[0]  <= '0;
			per_s[0]  <= in_data.period_ms;
			code_s[0] <= in_data.wave_code;
			hi_s[0]   <= in_data.high_limit;
			lo_s[0]   <= in_data.low_limit;
		end
	end

	// one quotient bit per stage; after the time bits the zeros shifted in
	// turn the remainder into the phase fraction
	for (genvar i = 0; i < N; i++) begin : g_div
		logic [24:0] trial;
		logic        ge;
		assign trial = {rem_s[i], dvd_s[i][31]};
		assign ge    = trial >= {1'b0, per_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? 24'(trial - {1'b0, per_s[i]}) : trial[23:0];
				dvd_s[i+1]  <= {dvd_s[i][30:0], 1'b0};
				quo_s[i+1]  <= {quo_s[i][PB-2:0], ge};
				per_s[i+1]  <= per_s[i];
				code_s[i+1] <= code_s[i];
				hi_s[i+1]   <= hi_s[i];
				lo_s[i+1]   <= lo_s[i];
			end
		end
	end

	// quarter-wave sine rom
	logic [16:0] sine_rom [0:QSZ];
	for (genvar g = 0; g <= QSZ; g++) begin : g_rom
		assign sine_rom[g] = quarter_sine(g, STB);
	end

	// wave shaping on the phase
	logic [PB-1:0] ph;
	logic [PB+1:0] ph_x;
	logic [PB+1:0] a_lin;
	logic [PB+1:0] tri2;
	logic [AW-1:0] a_sh;
	logic [QW-1:0] q_sh;
	logic [TB-1:0] q;
	logic [STB:0]  k_idx;
	logic signed [32:0] diff;

	assign ph   = quo_s[N];
	assign ph_x = (PB+2)'(ph);
	assign tri2 = ph_x << 1;

	always_comb begin
		case (code_s[N])
			WAVE_SAW:     a_lin = ph_x;
			WAVE_INV_SAW: a_lin = ONE - ph_x;
			WAVE_SQUARE:  a_lin = (ph != '0 && tri2 < ONE) ? ONE : '0;
			WAVE_TRI:     a_lin = (tri2 > ONE) ? (ONE << 1) - tri2 : tri2;
			default:      a_lin = '0;
		endcase
	end

	assign a_sh  = (AW'(a_lin) << UP) >> DN;
	assign q_sh  = (QW'(ph) << SUP) >> SDN;
	assign q     = q_sh[TB-1:0];
	assign k_idx = q[STB] ? (STB+1)'(QSZ) - (STB+1)'(q[STB-1:0])
	                      : (STB+1)'(q[STB-1:0]);
	assign diff  = 33'(hi_s[N]) - 33'(lo_s[N]);

	// e1: rom read, linear amplitude, limit difference
	logic        v_e1, sine_e1, qhi_e1, err_e1, neg_e1;
	logic [16:0] lin_e1, s_e1;
	logic [31:0] mag_e1;
	logic signed [31:0] lo_e1;

	// e2: amplitude
	logic        v_e2, err_e2, neg_e2;
	logic [16:0] amp_e2;
	logic [31:0] mag_e2;
	logic signed [31:0] lo_e2;

	// e3: product
	logic        v_e3, err_e3, neg_e3;
	logic [16:0] amp_e3;
	logic [48:0] prod_e3;
	logic signed [31:0] lo_e3;

	logic [17:0] s_up, s_dn;
	logic [16:0] amp_sel;
	logic signed [32:0] part, total;

	assign s_up    = (18'(AMP_ONE) + 18'(s_e1)) >> 1;
	assign s_dn    = (18'(AMP_ONE) - 18'(s_e1)) >> 1;
	assign amp_sel = err_e1 ? '0 :
	                 sine_e1 ? (qhi_e1 ? s_dn[16:0] : s_up[16:0]) : lin_e1;
	assign part    = neg_e3 ? -$signed({1'b0, prod_e3[47:16]})
	                        : $signed({1'b0, prod_e3[47:16]});
	assign total   = 33'(lo_e3) + part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1      <= 1'b0;
			v_e2      <= 1'b0;
			v_e3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_e1      <= v_s[N];
			v_e2      <= v_e1;
			v_e3      <= v_e2;
			out_valid <= v_e3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_e1  <= a_sh[16:0];
			sine_e1 <= code_s[N] == WAVE_SINE;
			qhi_e1  <= q[TB-1];
			s_e1    <= sine_rom[k_idx];
			err_e1  <= per_s[N] == '0;
			neg_e1  <= diff < 0;
			mag_e1  <= diff < 0 ? 32'(-diff) : diff[31:0];
			lo_e1   <= lo_s[N];

			amp_e2  <= amp_sel;
			err_e2  <= err_e1;
			neg_e2  <= neg_e1;
			mag_e2  <= mag_e1;
			lo_e2   <= lo_e1;

			prod_e3 <= 49'(mag_e2) * 49'(amp_e2);
			amp_e3  <= amp_e2;
			err_e3  <= err_e2;
			neg_e3  <= neg_e2;
			lo_e3   <= lo_e2;

			out_data.amplitude    <= amp_e3;
			out_data.above_half   <= amp_e3 > AMP_HALF;
			out_data.scaled_value <= total[31:0];
			out_data.period_error <= err_e3;
		end
	end

endmodule

@@ rtl/core/pwvg_checker.sv @@
// ----------------------------------------------------------------------------
// pwvg_checker
// Port-level checks for the periodic waveform value generator.
// ----------------------------------------------------------------------------
module pwvg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pwvg_pkg::pwvg_out_t out_data
);
	import pwvg_pkg::*;

	// a held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// the pipeline only stalls when the output is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.period_error |-> out_data.amplitude == '0)
		else $error("zero period with nonzero amplitude");

	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.amplitude <= AMP_ONE &&
			out_data.above_half == (out_data.amplitude > AMP_HALF))
		else $error("amplitude out of range or wrong half flag");

endmodule

bind periodic_waveform_value_generator pwvg_checker u_pwvg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
